/* hdl/pfx_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the postfix expression evaluator.
// Used by pfx_alu and postfix_expression_evaluator_top; no dependencies.

package pfx_pkg;

   // Sizing
   localparam int STACK_DEPTH  = 16;
   localparam int VALUE_WIDTH  = 32;
   localparam int RESULT_WIDTH = 32;
   localparam int ADDR_WIDTH   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COUNT_WIDTH  = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH);

   // Character codes
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_UNDERFLOW = 3'd1,
      STATUS_OVERFLOW  = 3'd2,
      STATUS_DIV_ZERO  = 3'd3,
      STATUS_BAD_CHAR  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ALU_OP_ADD,
      ALU_OP_SUB,
      ALU_OP_MUL,
      ALU_OP_DIV
   } alu_op_type;

   typedef struct packed {
      logic                   start;
      alu_op_type             op;
      logic [VALUE_WIDTH-1:0] lhs;
      logic [VALUE_WIDTH-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_expr;
   } req_payload_type;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] result_value;
      logic [2:0]                     status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RD_RHS,
      ST_RD_LHS,
      ST_ALU_RUN,
      ST_CHECK_END,
      ST_RESULT
   } ctl_state_type;

   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_DIV,
      ALU_FIX,
      ALU_DONE
   } alu_state_type;

   // Sign-extend or truncate a stack value to the result width.
   function automatic logic signed [RESULT_WIDTH-1:0] to_result(
      input logic [VALUE_WIDTH-1:0] value);
      logic signed [VALUE_WIDTH-1:0] sval;
      sval = value;
      return RESULT_WIDTH'(sval);
   endfunction

endpackage

/* hdl/pfx_alu.sv */
`timescale 1ns / 1ps
// Shared arithmetic unit: add, subtract, multiply and a radix-2 restoring
// divider that truncates toward zero. Depends on pfx_pkg.

module pfx_alu (
   input  logic                clock,
   input  logic                reset,
   input  pfx_pkg::alu_req_type alu_req,
   output pfx_pkg::alu_rsp_type alu_rsp
);

   localparam int W = pfx_pkg::VALUE_WIDTH;

   pfx_pkg::alu_state_type state_ff, state_in;

   logic [W-1:0]                      result_ff, result_in;
   logic [W-1:0]                      rem_ff, rem_in;
   logic [W-1:0]                      quo_ff, quo_in;
   logic [W-1:0]                      dvs_ff, dvs_in;
   logic                              neg_ff, neg_in;
   logic [pfx_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [W-1:0] lhs_mag, rhs_mag, product;
   logic [W:0]   shifted, trial;

   assign lhs_mag = alu_req.lhs[W-1] ? (W'(0) - alu_req.lhs) : alu_req.lhs;
   assign rhs_mag = alu_req.rhs[W-1] ? (W'(0) - alu_req.rhs) : alu_req.rhs;
   assign product = alu_req.lhs * alu_req.rhs;   // low bits only

   // One divider step: bring down next dividend bit, trial subtract.
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfx_pkg::ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      result_ff <= result_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      alu_rsp.done   = 1'b0;
      alu_rsp.result = result_ff;
      case (state_ff)
         pfx_pkg::ALU_IDLE: begin
            if (alu_req.start) begin
               case (alu_req.op)
                  pfx_pkg::ALU_OP_ADD: begin
                     result_in = alu_req.lhs + alu_req.rhs;
                     state_in  = pfx_pkg::ALU_DONE;
                  end
                  pfx_pkg::ALU_OP_SUB: begin
                     result_in = alu_req.lhs - alu_req.rhs;
                     state_in  = pfx_pkg::ALU_DONE;
                  end
                  pfx_pkg::ALU_OP_MUL: begin
                     result_in = product;
                     state_in  = pfx_pkg::ALU_DONE;
                  end
                  default: begin
                     rem_in   = '0;
                     quo_in   = lhs_mag;
                     dvs_in   = rhs_mag;
                     neg_in   = alu_req.lhs[W-1] ^ alu_req.rhs[W-1];
                     cnt_in   = '0;
                     state_in = pfx_pkg::ALU_DIV;
                  end
               endcase
            end
         end
         pfx_pkg::ALU_DIV: begin
            if (!trial[W]) begin
               rem_in = trial[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + pfx_pkg::DIV_CNT_WIDTH'(1);
            if (cnt_ff == pfx_pkg::DIV_CNT_WIDTH'(W - 1)) begin
               state_in = pfx_pkg::ALU_FIX;
            end
         end
         pfx_pkg::ALU_FIX: begin
            // Min value / -1 falls out as the min value again.
            result_in = neg_ff ? (W'(0) - quo_ff) : quo_ff;
            state_in  = pfx_pkg::ALU_DONE;
         end
         pfx_pkg::ALU_DONE: begin
            alu_rsp.done = 1'b1;
            state_in     = pfx_pkg::ALU_IDLE;
         end
         default: begin
            state_in = pfx_pkg::ALU_IDLE;
         end
      endcase
   end

endmodule

/* hdl/postfix_expression_evaluator_top.sv */
`timescale 1ns / 1ps
// Top level of the postfix (RPN) expression evaluator: control sequencer,
// operand stack memory and output register. Depends on pfx_pkg and pfx_alu.

// One beat on req_ carries one ASCII character of a postfix expression; the
// beat flagged end_of_expr closes the expression and produces exactly one
// beat on rsp_ with the top-of-stack value and a status (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad character; value is 0 on any error).
// Digits push, + - * / pop two and push one, all with wrap-around 32-bit
// two's complement; division truncates toward zero. The first error of an
// expression sticks and the rest of its characters are skipped. The block
// handles one character at a time and drops req_ready while it works;
// / runs the bit-serial divider in the shared ALU (one quotient bit per
// cycle). The closing character then goes on to load the output register,
// and waits there only if the previous response has not yet been taken.
// The stack sits in a small memory with one write and one registered read
// port, so each operand comes through that read register. No clearing
// pass is needed after reset.

module postfix_expression_evaluator_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pfx_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pfx_pkg::rsp_payload_type rsp_data
);

   localparam int W  = pfx_pkg::VALUE_WIDTH;
   localparam int AW = pfx_pkg::ADDR_WIDTH;
   localparam int CW = pfx_pkg::COUNT_WIDTH;

   pfx_pkg::ctl_state_type state_ff, state_in;

   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic [CW-1:0]       count_ff, count_in;
   pfx_pkg::status_type err_ff, err_in;
   logic [W-1:0]        rhs_ff, rhs_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   pfx_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                     rsp_load;

   // Operand stack memory
   logic [W-1:0]  stack_mem [pfx_pkg::STACK_DEPTH];
   logic [W-1:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [W-1:0]  wr_data;

   logic [CW-1:0] count_m1, count_m2;
   logic          is_digit, is_oper;
   pfx_pkg::alu_op_type alu_op;

   pfx_pkg::alu_req_type alu_req;
   pfx_pkg::alu_rsp_type alu_rsp;

   pfx_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);

   assign is_digit = char_ff inside {[pfx_pkg::CHAR_ZERO:pfx_pkg::CHAR_NINE]};
   assign is_oper  = (char_ff == pfx_pkg::CHAR_PLUS)  || (char_ff == pfx_pkg::CHAR_MINUS) ||
                     (char_ff == pfx_pkg::CHAR_STAR)  || (char_ff == pfx_pkg::CHAR_SLASH);

   always_comb begin
      case (char_ff)
         pfx_pkg::CHAR_PLUS:  alu_op = pfx_pkg::ALU_OP_ADD;
         pfx_pkg::CHAR_MINUS: alu_op = pfx_pkg::ALU_OP_SUB;
         pfx_pkg::CHAR_STAR:  alu_op = pfx_pkg::ALU_OP_MUL;
         default:             alu_op = pfx_pkg::ALU_OP_DIV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfx_pkg::ST_IDLE;
         count_ff     <= '0;
         err_ff       <= pfx_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      rhs_ff      <= rhs_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Sequencer: next state, stack port control, ALU launch, response load.
   always_comb begin
      state_in  = state_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      rhs_in    = rhs_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      rd_addr   = count_m1[AW-1:0];   // top of stack by default
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      // '0'..'9' carry their value in the low nibble
      wr_data   = {{(W-4){1'b0}}, char_ff[3:0]};
      alu_req.start = 1'b0;
      alu_req.op    = alu_op;
      alu_req.lhs   = rd_data_ff;
      alu_req.rhs   = rhs_ff;
      case (state_ff)
         pfx_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               char_in  = req_data.char_code;
               last_in  = req_data.end_of_expr;
               state_in = pfx_pkg::ST_EXEC;
            end
         end
         pfx_pkg::ST_EXEC: begin
            state_in = pfx_pkg::ST_CHECK_END;
            if (err_ff == pfx_pkg::STATUS_OK) begin
               if (is_digit) begin
                  if (count_ff == CW'(pfx_pkg::STACK_DEPTH)) begin
                     err_in = pfx_pkg::STATUS_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (!is_oper) begin
                  err_in = pfx_pkg::STATUS_BAD_CHAR;
               end else if (count_ff < CW'(2)) begin
                  err_in = pfx_pkg::STATUS_UNDERFLOW;
               end else begin
                  state_in = pfx_pkg::ST_RD_RHS;   // rhs read issued here
               end
            end
         end
         pfx_pkg::ST_RD_RHS: begin
            rhs_in   = rd_data_ff;
            rd_addr  = count_m2[AW-1:0];
            state_in = pfx_pkg::ST_RD_LHS;
         end
         pfx_pkg::ST_RD_LHS: begin
            rd_addr = count_m2[AW-1:0];
            if ((alu_op == pfx_pkg::ALU_OP_DIV) && (rhs_ff == '0)) begin
               err_in   = pfx_pkg::STATUS_DIV_ZERO;
               state_in = pfx_pkg::ST_CHECK_END;
            end else begin
               alu_req.start = 1'b1;
               state_in      = pfx_pkg::ST_ALU_RUN;
            end
         end
         pfx_pkg::ST_ALU_RUN: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = count_m2[AW-1:0];
               wr_data  = alu_rsp.result;
               count_in = count_m1;
               state_in = pfx_pkg::ST_CHECK_END;
            end
         end
         pfx_pkg::ST_CHECK_END: begin
            // Top-of-stack read issued here lands in rd_data_ff for RESULT.
            if (!last_ff) begin
               state_in = pfx_pkg::ST_IDLE;
            end else begin
               if ((err_ff == pfx_pkg::STATUS_OK) && (count_ff == '0)) begin
                  err_in = pfx_pkg::STATUS_UNDERFLOW;
               end
               state_in = pfx_pkg::ST_RESULT;
            end
         end
         pfx_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               count_in = '0;
               err_in   = pfx_pkg::STATUS_OK;
               state_in = pfx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfx_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.status = err_ff;
         rsp_data_in.result_value = (err_ff == pfx_pkg::STATUS_OK) ?
                                    pfx_pkg::to_result(rd_data_ff) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pfx_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_alu_needs_two: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> (count_ff >= CW'(2)) && (err_ff == pfx_pkg::STATUS_OK))
      else $error("ALU launched without two operands or after an error");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != pfx_pkg::STATUS_OK)) |->
         (rsp_data.result_value == '0))
      else $error("nonzero value reported with an error status");

   a_clear_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (count_ff == '0) && (err_ff == pfx_pkg::STATUS_OK) && rsp_valid_ff)
      else $error("expression state not cleared after response");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == pfx_pkg::ST_EXEC)) |->
         (count_ff < CW'(pfx_pkg::STACK_DEPTH)))
      else $error("push into a full stack");
`endif

endmodule

/* tb/postfix_expression_evaluator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for postfix_expression_evaluator_top: a directed table of characters,
// then random RPN expressions, scored against a stack predictor kept in the bench (pinned
// directed rows use a hand-written answer). Depends on pfx_pkg and the evaluator RTL.

module postfix_expression_evaluator_top_tb;

   localparam int     HALF_PERIOD   = 2;
   localparam int     RESET_CYCLES  = 7;
   localparam int     DIRECTED_ROWS = 25;
   localparam int     RANDOM_BEATS  = 700;
   localparam int     HOLD_AFTER    = 300;   // beats sent before the long receiver hold-off
   localparam int     HOLD_CYCLES   = 400;
   localparam int     DRAIN_CYCLES  = 64;
   localparam int     MAX_REPORTS   = 10;
   localparam longint TIMEOUT_NS    = 2_000_000;

   localparam logic [7:0] OP_CHARS [4] = '{pfx_pkg::CHAR_PLUS, pfx_pkg::CHAR_MINUS,
                                           pfx_pkg::CHAR_STAR, pfx_pkg::CHAR_SLASH};

   // One directed row. pinned = expected answer typed in here rather than predicted.
   typedef struct packed {
      logic [7:0]                              ch;
      logic                                    last;
      logic                                    pinned;
      logic signed [pfx_pkg::RESULT_WIDTH-1:0] value;
      pfx_pkg::status_type                     status;
   } directed_row_type;

   // One queued input beat, with an optional hand-written answer.
   typedef struct packed {
      pfx_pkg::req_payload_type beat;
      logic                     pinned;
      pfx_pkg::rsp_payload_type pinned_rsp;
   } char_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pfx_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   pfx_pkg::rsp_payload_type rsp_data;

   postfix_expression_evaluator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Stimulus still to send and answers still owed by the block.
   char_beat_type            char_q [$];
   pfx_pkg::rsp_payload_type pending_answers [$];
   directed_row_type         directed_tbl [DIRECTED_ROWS];

   // Predictor state: operand stack, fill level and sticky error of the open expression.
   logic [pfx_pkg::VALUE_WIDTH-1:0] model_stack [pfx_pkg::STACK_DEPTH];
   int                              model_depth;
   pfx_pkg::status_type             model_err;

   int chars_sent;
   int mismatches;
   int status_hist [5];

   // ---------------------------------------------------------------------------------------
   // Predictor: apply one character; on the closing one, hand back the answer and clear.
   // ---------------------------------------------------------------------------------------
   task automatic eval_char(input pfx_pkg::req_payload_type beat, output logic done,
                            output pfx_pkg::rsp_payload_type ans);
      logic [pfx_pkg::VALUE_WIDTH-1:0] lhs, rhs, res, mag_l, mag_r;
      logic                            div_zero;
      done     = beat.end_of_expr;
      ans      = '0;
      div_zero = 1'b0;
      res      = '0;
      // once an error is set, everything up to the closing character is skipped
      if (model_err == pfx_pkg::STATUS_OK) begin
         if (beat.char_code >= pfx_pkg::CHAR_ZERO && beat.char_code <= pfx_pkg::CHAR_NINE) begin
            if (model_depth >= pfx_pkg::STACK_DEPTH) begin
               model_err = pfx_pkg::STATUS_OVERFLOW;
            end else begin
               model_stack[model_depth] =
                  pfx_pkg::VALUE_WIDTH'(beat.char_code - pfx_pkg::CHAR_ZERO);
               model_depth++;
            end
         end else begin
            case (beat.char_code)
               pfx_pkg::CHAR_PLUS, pfx_pkg::CHAR_MINUS,
               pfx_pkg::CHAR_STAR, pfx_pkg::CHAR_SLASH: begin
                  if (model_depth < 2) begin
                     model_err = pfx_pkg::STATUS_UNDERFLOW;
                  end else begin
                     rhs = model_stack[model_depth-1];
                     lhs = model_stack[model_depth-2];
                     case (beat.char_code)
                        pfx_pkg::CHAR_PLUS:  res = lhs + rhs;
                        pfx_pkg::CHAR_MINUS: res = lhs - rhs;
                        pfx_pkg::CHAR_STAR:  res = lhs * rhs;
                        default: begin
                           if (rhs == '0) begin
                              div_zero = 1'b1;
                           end else begin
                              // magnitudes, unsigned divide, then fix the sign;
                              // most negative / -1 wraps back to itself
                              mag_l = lhs[pfx_pkg::VALUE_WIDTH-1] ? -lhs : lhs;
                              mag_r = rhs[pfx_pkg::VALUE_WIDTH-1] ? -rhs : rhs;
                              res   = mag_l / mag_r;
                              if (lhs[pfx_pkg::VALUE_WIDTH-1] ^ rhs[pfx_pkg::VALUE_WIDTH-1])
                                 res = -res;
                           end
                        end
                     endcase
                     if (div_zero) begin
                        model_err = pfx_pkg::STATUS_DIV_ZERO;
                     end else begin
                        model_depth--;
                        model_stack[model_depth-1] = res;
                     end
                  end
               end
               default: model_err = pfx_pkg::STATUS_BAD_CHAR;
            endcase
         end
      end
      if (beat.end_of_expr) begin
         if (model_err == pfx_pkg::STATUS_OK && model_depth == 0)
            model_err = pfx_pkg::STATUS_UNDERFLOW;
         ans.status = model_err;
         if (model_err == pfx_pkg::STATUS_OK) begin
            ans.result_value =
               pfx_pkg::RESULT_WIDTH'($signed(model_stack[model_depth-1]));
         end
         model_depth = 0;
         model_err   = pfx_pkg::STATUS_OK;
      end
   endtask

   task automatic add_beat(input logic [7:0] ch, input logic last);
      char_beat_type row;
      row.beat.char_code   = ch;
      row.beat.end_of_expr = last;
      row.pinned           = 1'b0;
      row.pinned_rsp       = '0;
      char_q.push_back(row);
   endtask

   // ---------------------------------------------------------------------------------------
   // Random part. Mostly well-formed expressions with random digits and operators (these
   // reach division, wrap and deep stacks); some fill the stack to and past the top; some
   // build the most negative value and hit it with -1; the rest is noise over all 256 codes.
   // Noise beats are largely skipped by the block and are not counted.
   // ---------------------------------------------------------------------------------------
   task automatic build_random_part();
      int         useful, depth, goal, len, kind, i;
      logic [7:0] ch;
      logic       last;
      useful = 0;
      while (useful < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            goal  = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 31) : $urandom_range(1, 9);
            depth = 0;
            len   = 0;
            last  = 1'b0;
            while (!last) begin
               if (depth < 2 || (len < goal && depth < pfx_pkg::STACK_DEPTH &&
                                 $urandom_range(0, 1) == 0)) begin
                  ch = pfx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
                  depth++;
               end else begin
                  ch = OP_CHARS[$urandom_range(0, 3)];
                  depth--;
               end
               len++;
               last = (depth == 1 && len >= goal);
               add_beat(ch, last);
            end
            useful += len;
         end else if (kind < 78) begin
            // full stack; one digit too many gives overflow
            len  = $urandom_range(pfx_pkg::STACK_DEPTH - 2, pfx_pkg::STACK_DEPTH + 2);
            goal = $urandom_range(0, 3);
            for (i = 0; i < len; i++) begin
               add_beat(pfx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)),
                        goal == 0 && i == len - 1);
            end
            for (i = 0; i < goal; i++) add_beat(OP_CHARS[$urandom_range(0, 3)], i == goal - 1);
            useful += len + goal;
         end else if (kind < 84) begin
            // 8^10 * 2 wraps to the most negative value; then 0 1 - gives -1
            add_beat(pfx_pkg::CHAR_ZERO + 8'd8, 1'b0);
            for (i = 0; i < 9; i++) begin
               add_beat(pfx_pkg::CHAR_ZERO + 8'd8, 1'b0);
               add_beat(pfx_pkg::CHAR_STAR, 1'b0);
            end
            add_beat(pfx_pkg::CHAR_ZERO + 8'd2, 1'b0);
            add_beat(pfx_pkg::CHAR_STAR, 1'b0);
            add_beat(pfx_pkg::CHAR_ZERO, 1'b0);
            add_beat(pfx_pkg::CHAR_ZERO + 8'd1, 1'b0);
            add_beat(pfx_pkg::CHAR_MINUS, 1'b0);
            add_beat($urandom_range(0, 1) ? pfx_pkg::CHAR_SLASH : OP_CHARS[$urandom_range(0, 3)],
                     1'b1);
            useful += 25;
         end else begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 1)) ch = 8'($urandom_range(0, 255));
               else if ($urandom_range(0, 1)) ch = OP_CHARS[$urandom_range(0, 3)];
               else ch = pfx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
               add_beat(ch, i == len - 1);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence: build stimulus, reset, send beats in bursts with random gaps, drain.
   // Every accepted beat goes through the predictor at the accepting edge; closing beats
   // queue their answer (hand-written one for pinned directed rows).
   // ---------------------------------------------------------------------------------------
   initial begin : char_sender
      char_beat_type            row;
      logic                     has_ans;
      pfx_pkg::rsp_payload_type ans;
      int                       burst_left, gap;

      req_valid   = 1'b0;
      req_data    = '0;
      reset       = 1'b1;
      model_depth = 0;
      model_err   = pfx_pkg::STATUS_OK;
      chars_sent  = 0;
      mismatches  = 0;
      for (int s = 0; s < 5; s++) status_hist[s] = 0;

      directed_tbl = '{
         // single digits at both ends of the range
         '{pfx_pkg::CHAR_ZERO,        1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_NINE,        1'b1, 1'b1, 32'sd9, pfx_pkg::STATUS_OK},
         // operator with an empty stack, then with only one value
         '{pfx_pkg::CHAR_PLUS,        1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_UNDERFLOW},
         '{pfx_pkg::CHAR_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_MINUS,       1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_UNDERFLOW},
         // codes at both ends of the byte are bad characters
         '{8'hFF,                     1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_BAD_CHAR},
         '{8'h00,                     1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_BAD_CHAR},
         // 8 0 /
         '{pfx_pkg::CHAR_ZERO + 8'd8, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_ZERO,        1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_SLASH,       1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_DIV_ZERO},
         // 3 7 - 2 / : negative dividend divides exactly to -2
         '{pfx_pkg::CHAR_ZERO + 8'd3, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_ZERO + 8'd7, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_MINUS,       1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_SLASH,       1'b1, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         // 9 9 *
         '{pfx_pkg::CHAR_NINE,        1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_NINE,        1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_STAR,        1'b1, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         // bad character mid-expression sticks; the operator after it is skipped
         '{pfx_pkg::CHAR_ZERO + 8'd4, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{8'h78,                     1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_PLUS,        1'b1, 1'b1, 32'sd0, pfx_pkg::STATUS_BAD_CHAR},
         // 5 6 2 + : value left under the top is not an error
         '{pfx_pkg::CHAR_ZERO + 8'd5, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_ZERO + 8'd6, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_ZERO + 8'd2, 1'b0, 1'b0, 32'sd0, pfx_pkg::STATUS_OK},
         '{pfx_pkg::CHAR_PLUS,        1'b1, 1'b0, 32'sd0, pfx_pkg::STATUS_OK}
      };
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row.beat.char_code           = directed_tbl[r].ch;
         row.beat.end_of_expr         = directed_tbl[r].last;
         row.pinned                   = directed_tbl[r].pinned;
         row.pinned_rsp.result_value  = directed_tbl[r].value;
         row.pinned_rsp.status        = directed_tbl[r].status;
         char_q.push_back(row);
      end
      build_random_part();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      while (char_q.size() != 0) begin
         // new burst: sometimes back-to-back, otherwise a short idle gap first
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         row = char_q.pop_front();
         req_valid <= 1'b1;
         req_data  <= row.beat;
         do @(posedge clock); while (req_ready !== 1'b1);
         chars_sent++;
         burst_left--;
         eval_char(row.beat, has_ans, ans);
         if (has_ans) pending_answers.push_back(row.pinned ? row.pinned_rsp : ans);
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d characters, %0d results: ok %0d, underflow %0d, overflow %0d,",
               chars_sent, status_hist[0] + status_hist[1] + status_hist[2] + status_hist[3]
               + status_hist[4], status_hist[0], status_hist[1], status_hist[2]);
      $display("  divide by zero %0d, bad character %0d; %0d mismatches",
               status_hist[3], status_hist[4], mismatches);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Result side: ready steps through a random 8-bit mask that a tick counter redraws (often
   // all ones). Once, after HOLD_AFTER beats, ready drops for HOLD_CYCLES so the output
   // register fills and the block has to push back on req_.
   // ---------------------------------------------------------------------------------------
   initial begin : answer_drain
      logic [7:0]  stall_mask;
      int unsigned tick;
      logic        held_off;
      rsp_ready  = 1'b0;
      stall_mask = 8'hFF;
      tick       = 0;
      held_off   = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && chars_sent >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (tick % 64 == 0) begin
            stall_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
         end
         rsp_ready <= stall_mask[tick % 8];
         tick++;
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Scoreboard: each accepted result beat against the oldest owed answer.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : answer_check
      pfx_pkg::rsp_payload_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (got.status <= pfx_pkg::STATUS_BAD_CHAR) status_hist[got.status]++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR @%0t: unexpected result, value %0d status %0d",
                        $time, got.result_value, got.status);
            end
         end else begin
            want = pending_answers.pop_front();
            if (got.result_value !== want.result_value || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR @%0t: expected value %0d status %0d, got value %0d status %0d",
                           $time, want.result_value, want.status,
                           got.result_value, got.status);
               end
            end
         end
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timeout with %0d results outstanding", pending_answers.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
